[rtl/ildl_pkg.sv]
package ildl_pkg;

    // Field widths of the request and response words.
    localparam int ACTION_W = 2;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Default list geometry.
    localparam int DEPTH_DEF = 64;
    localparam int WIDTH_DEF = 32;

    // Request kinds. Code 3 has no meaning and is refused.
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell. At most one flag is set, and only
    // for a request that has passed its range and full checks.
    typedef struct packed {
        logic ins;
        logic rem;
        logic rd;
    } t_cell_op;

endpackage

[rtl/ildl_req_if.sv]
interface ildl_req_if;
    import ildl_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [VALUE_W-1:0]  value_in;

    modport source (output valid, output action, output position, output value_in,
                    input ready);
    modport sink   (input valid, input action, input position, input value_in,
                    output ready);
endinterface

[rtl/ildl_rsp_if.sv]
interface ildl_rsp_if;
    import ildl_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output value_out, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input value_out, input entry_count,
                    output ready);
endinterface

[rtl/ildl_cell.sv]
module ildl_cell #(
    parameter int WIDTH = 32,
    parameter int IDX   = 0
) (
    input  logic                         i_clk,
    input  logic                         i_accept,
    input  ildl_pkg::t_cell_op           i_op,
    input  logic [ildl_pkg::POS_W-1:0]   i_pos,
    input  logic [WIDTH-1:0]             i_new,
    input  logic [WIDTH-1:0]             i_prev,
    input  logic [WIDTH-1:0]             i_next,
    output logic [WIDTH-1:0]             o_entry,
    output logic [WIDTH-1:0]             o_tap
);
    import ildl_pkg::*;

    logic [WIDTH-1:0] r_entry;
    logic [WIDTH-1:0] n_entry;
    logic [WIDTH-1:0] r_tap;
    logic             w_here;
    logic             w_above;

    // Where this cell sits relative to the requested position.
    assign w_here  = (32'(i_pos) == 32'(IDX));
    assign w_above = (32'(IDX) > 32'(i_pos));

    // An insert opens a gap at the position and moves later words up; a
    // remove closes the gap by pulling later words down.
    always_comb begin
        n_entry = r_entry;
        if (i_op.ins) begin
            if (w_here) begin
                n_entry = i_new;
            end else if (w_above) begin
                n_entry = i_prev;
            end
        end else if (i_op.rem) begin
            if (w_here || w_above) begin
                n_entry = i_next;
            end
        end
    end

    // The entry word and the read tap change only when a word is accepted.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_entry <= n_entry;
            r_tap   <= (i_op.rd && w_here) ? r_entry : '0;
        end
    end

    assign o_entry = r_entry;
    assign o_tap   = r_tap;

endmodule

[rtl/indexed_insert_delete_list_core.sv]
// Channel | Dir | Payload                              | Accepted when
// i_req   | in  | action, position, value_in           | valid && ready
// o_rsp   | out | status, value_out, entry_count       | valid && ready
//
// One request per cycle is sustained while the output is not stalled.
// A request passes through the cell row, where each cell shifts or holds and
// latches its read tap, and then through the output register, which takes
// the OR of the taps.
// Reset clears the entry count and the pipeline valid flags; the stored
// words are not cleared, and no request is taken while reset is held.
// A stalled output holds its response, and the request side stalls with it
// once both stages are occupied.
module indexed_insert_delete_list_core #(
    parameter int DEPTH = ildl_pkg::DEPTH_DEF,
    parameter int WIDTH = ildl_pkg::WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ildl_req_if.sink    i_req,
    ildl_rsp_if.source  o_rsp
);
    import ildl_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_s1_v;
    t_status          r_s1_status;
    logic [COUNT_W-1:0] r_s1_count;
    logic             r_o_v;
    t_status          r_o_status;
    logic [VALUE_W-1:0] r_o_value;
    logic [COUNT_W-1:0] r_o_count;

    logic             w_en_o;
    logic             w_en_s1;
    logic             w_accept;
    logic [CMPW-1:0]  w_pos;
    logic [CMPW-1:0]  w_cnt;
    t_status          w_status;
    t_cell_op         w_op;
    t_cell_op         w_op_gated;
    logic [WIDTH-1:0] w_new;
    logic [WIDTH-1:0] w_entry [DEPTH];
    logic [WIDTH-1:0] w_tap   [DEPTH];
    logic [WIDTH-1:0] w_rd;

    // Pipeline flow control: each stage loads when the one after it frees.
    // No request is taken while reset is held.
    assign w_en_o      = !r_o_v || o_rsp.ready;
    assign w_en_s1     = !r_s1_v || w_en_o;
    assign i_req.ready = w_en_s1 && i_rst_n;
    assign w_accept    = i_req.valid && w_en_s1 && i_rst_n;

    assign w_pos = CMPW'(i_req.position);
    assign w_cnt = CMPW'(r_count);
    assign w_new = WIDTH'(i_req.value_in);

    // Range and full checks, and the operation sent to the cells.
    always_comb begin
        w_op     = '0;
        w_status = ST_RANGE;
        n_count  = r_count;
        case (t_action'(i_req.action))
            ACT_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else if (r_count == CW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_status = ST_DONE;
                    w_op.ins = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            ACT_REMOVE: begin
                if (w_pos < w_cnt) begin
                    w_status = ST_DONE;
                    w_op.rem = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            ACT_READ: begin
                if (w_pos < w_cnt) begin
                    w_status = ST_DONE;
                    w_op.rd  = 1'b1;
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    assign w_op_gated = w_accept ? w_op : '0;

    // Row of cells; the ends see zero where they have no neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] w_prev;
        logic [WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_entry[g+1];
        end

        ildl_cell #(
            .WIDTH (WIDTH),
            .IDX   (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_accept (w_accept),
            .i_op     (w_op_gated),
            .i_pos    (i_req.position),
            .i_new    (w_new),
            .i_prev   (w_prev),
            .i_next   (w_next),
            .o_entry  (w_entry[g]),
            .o_tap    (w_tap[g])
        );
    end

    // At most one cell holds a nonzero tap, so an OR picks the read word.
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd = w_rd | w_tap[k];
        end
    end

    // Count and pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_s1_v  <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_en_s1) begin
                r_s1_v <= i_req.valid;
            end
            if (w_en_o) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_status;
            r_s1_count  <= COUNT_W'(n_count);
        end
        if (w_en_o && r_s1_v) begin
            r_o_status <= r_s1_status;
            r_o_value  <= VALUE_W'(w_rd);
            r_o_count  <= r_s1_count;
        end
    end

    assign o_rsp.valid       = r_o_v;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.value_out   = r_o_value;
    assign o_rsp.entry_count = r_o_count;

`ifndef SYNTHESIS
    // The count never runs past the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds capacity");

    // A successful insert grows the list by exactly one.
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op.ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list by one");

    // A successful remove shrinks the list by exactly one.
    a_rem_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op.rem) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the list by one");

    // A nonzero read word only comes with a completed request.
    a_value_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && (r_o_value != '0)) |-> (r_o_status == ST_DONE))
        else $error("read word on a refused request");

    // A full refusal reports a full list.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && (r_o_status == ST_FULL)) |-> (r_o_count == COUNT_W'(DEPTH)))
        else $error("full status with a count below capacity");
`endif

endmodule
